### src/brf_pkg.sv
// shared types and constants for the bitmap range fill block
`default_nettype none

package brf_pkg;

  localparam int unsigned MAP_BITS    = 4096;
  localparam int unsigned WORD_BITS   = 8;
  localparam int unsigned MAP_WORDS   = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WORD_SEL_W  = $clog2(WORD_BITS);
  localparam int unsigned WORD_ADDR_W = $clog2(MAP_WORDS);
  localparam int unsigned RANGE_W     = 12;
  localparam int unsigned INDEX_W     = 9;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned STATUS_W    = 2;

  typedef logic [WORD_BITS-1:0]   word_t;
  typedef logic [WORD_ADDR_W-1:0] waddr_t;

  localparam logic [OP_W-1:0] OP_SET  = 2'd0;
  localparam logic [OP_W-1:0] OP_CLR  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BEYOND = 2'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_RESP
  } state_e;

endpackage

`default_nettype wire

### src/bitmap_range_fill.sv
// bit map in byte memory with range set, range clear and byte read requests
//
// input channel: in_valid_i / in_stall_o carries op_i, range_low_i, range_high_i,
// byte_index_i. output channel: out_valid_o / out_stall_i carries read_byte_o and
// status_o. every request gives exactly one result, in order.
// a set or clear request walks the spanned bytes through one read-modify-write
// path on the map memory: one byte per cycle, the read of the next byte
// overlapping the masked write of the current one. a fill walks the fill state
// over bytes range_low/8 to range_high/8, then the response state loads the
// output register; a read, an empty range or an unused op goes to it directly.
// one request is in work at a time; the next is accepted once the current one
// has moved into the output register, so a finished result may wait there while
// the following request is taken.
// after reset the 512-byte map is zeroed by a clearing pass during which
// in_stall_o stays high.
// while out_stall_i holds a result, it stays in place and a following request
// that finishes waits for the output register to free up.
`default_nettype none

module bitmap_range_fill
  import brf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [OP_W-1:0]     op_i,
  input  wire logic [RANGE_W-1:0]  range_low_i,
  input  wire logic [RANGE_W-1:0]  range_high_i,
  input  wire logic [INDEX_W-1:0]  byte_index_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [WORD_BITS-1:0]     read_byte_o,
  output logic [STATUS_W-1:0]      status_o
);

  word_t mem [MAP_WORDS];

  state_e state_q, state_d;

  waddr_t              cur_q, cur_d;
  waddr_t              hw_q, hw_d;
  waddr_t              lw_q, lw_d;
  logic [WORD_SEL_W-1:0] lb_q, lb_d;
  logic [WORD_SEL_W-1:0] hb_q, hb_d;
  logic                ones_q, ones_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic                res_rd_q, res_rd_d;
  waddr_t              clr_cnt_q;

  logic                out_valid_q;
  word_t               out_byte_q;
  logic [STATUS_W-1:0] out_status_q;

  word_t  rd_data_q;
  logic   rd_en;
  waddr_t rd_addr;
  logic   wr_en;
  waddr_t wr_addr;
  word_t  wr_data;
  word_t  mask;

  logic accept;
  logic out_free;
  logic load_out;
  logic fill_empty;
  logic fill_beyond;
  logic read_beyond;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign fill_empty  = range_high_i < range_low_i;
  assign fill_beyond = {1'b0, range_high_i} >= (RANGE_W+1)'(MAP_BITS);
  assign read_beyond = {1'b0, byte_index_i} >= (INDEX_W+1)'(MAP_WORDS);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_cnt_q == WORD_ADDR_W'(MAP_WORDS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if ((op_i == OP_SET || op_i == OP_CLR) && !fill_empty && !fill_beyond) begin
            state_d = S_FILL;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_FILL: begin
        if (cur_q == hw_q) state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // edge masks for the first and last byte of the range
  always_comb begin
    mask = '1;
    if (cur_q == lw_q) mask = mask & (word_t'('1) << lb_q);
    if (cur_q == hw_q) mask = mask & (word_t'('1) >> (WORD_SEL_W'(WORD_BITS - 1) - hb_q));
  end

  // outputs and datapath control
  always_comb begin
    in_stall_o   = (state_q != S_IDLE);
    cur_d        = cur_q;
    hw_d         = hw_q;
    lw_d         = lw_q;
    lb_d         = lb_q;
    hb_d         = hb_q;
    ones_d       = ones_q;
    res_status_d = res_status_q;
    res_rd_d     = res_rd_q;
    rd_en        = 1'b0;
    rd_addr      = cur_q;
    wr_en        = 1'b0;
    wr_addr      = cur_q;
    wr_data      = ones_q ? (rd_data_q | mask) : (rd_data_q & ~mask);
    load_out     = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_q;
        wr_data = '0;
      end
      S_IDLE: begin
        if (accept) begin
          lw_d         = range_low_i[RANGE_W-1:WORD_SEL_W];
          hw_d         = range_high_i[RANGE_W-1:WORD_SEL_W];
          cur_d        = range_low_i[RANGE_W-1:WORD_SEL_W];
          lb_d         = range_low_i[WORD_SEL_W-1:0];
          hb_d         = range_high_i[WORD_SEL_W-1:0];
          ones_d       = (op_i == OP_SET);
          res_rd_d     = 1'b0;
          res_status_d = ST_DONE;
          unique case (op_i) inside
            OP_SET, OP_CLR: begin
              rd_en   = 1'b1;
              rd_addr = range_low_i[RANGE_W-1:WORD_SEL_W];
              if (fill_empty) res_status_d = ST_EMPTY;
              else if (fill_beyond) res_status_d = ST_BEYOND;
            end
            OP_READ: begin
              rd_en   = 1'b1;
              rd_addr = byte_index_i[WORD_ADDR_W-1:0];
              if (read_beyond) res_status_d = ST_BEYOND;
              else res_rd_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        wr_en = 1'b1;
        if (cur_q != hw_q) begin
          rd_en   = 1'b1;
          rd_addr = cur_q + 1'b1;
          cur_d   = cur_q + 1'b1;
        end
      end
      S_RESP: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  // map memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    hw_q         <= hw_d;
    lw_q         <= lw_d;
    lb_q         <= lb_d;
    hb_q         <= hb_d;
    ones_q       <= ones_d;
    res_status_q <= res_status_d;
    res_rd_q     <= res_rd_d;
    if (load_out) begin
      out_byte_q   <= res_rd_q ? rd_data_q : '0;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_byte_o = out_byte_q;
  assign status_o    = out_status_q;

endmodule

`default_nettype wire
